[sv/ctc_pkg.sv]
package ctc_pkg;

	localparam int ID_SLOTS = 4;
	localparam int LIMIT_W = 16;
	localparam int BYTE_W = 8;
	localparam int CMD_W = 3;
	localparam int INDEX_W = 3;

	// command field codes
	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STATUS = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CHAR = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SINGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ALL = 3'd4;

	// operation field codes
	localparam logic [BYTE_W-1:0] OPC_CLOSE = 8'h00;
	localparam logic [BYTE_W-1:0] OPC_OPEN = 8'h01;
	localparam logic [BYTE_W-1:0] OPC_STOP = 8'h02;

	localparam logic [3:0] ALL_NIBBLE = 4'hF;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_LIMIT = 3'd0;
	localparam logic [INDEX_W-1:0] REG_ID0 = 3'd1;
	localparam logic [INDEX_W-1:0] REG_ID1 = 3'd2;
	localparam logic [INDEX_W-1:0] REG_ID2 = 3'd3;
	localparam logic [INDEX_W-1:0] REG_ID3 = 3'd4;
	localparam logic [INDEX_W-1:0] REG_VERSION = 3'd5;
	localparam logic [INDEX_W-1:0] REG_MAKER = 3'd6;
	localparam logic [INDEX_W-1:0] REG_FEATURE = 3'd7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd100;
	localparam logic [BYTE_W-1:0] VERSION_RESET = 8'hFF;
	localparam logic [BYTE_W-1:0] MAKER_RESET = 8'hFF;
	localparam logic [BYTE_W-1:0] FEATURE_RESET = 8'h00;

	// response types and status codes
	localparam logic [BYTE_W-1:0] RSP_STATUS = 8'h81;
	localparam logic [BYTE_W-1:0] RSP_CHAR = 8'h8F;
	localparam logic [BYTE_W-1:0] RSP_CTRL = 8'hC1;
	localparam logic [BYTE_W-1:0] CODE_CLOSED = 8'h02;
	localparam logic [BYTE_W-1:0] CODE_OPENED = 8'h01;
	localparam logic [BYTE_W-1:0] CODE_CLOSING = 8'h04;
	localparam logic [BYTE_W-1:0] CODE_OPENING = 8'h08;
	localparam logic [BYTE_W-1:0] CODE_STOPPED = 8'h00;

	typedef enum logic [2:0] {
		K_TICK = 3'd0,
		K_STATUS = 3'd1,
		K_CHAR = 3'd2,
		K_SINGLE = 3'd3,
		K_ALL = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		OP_CLOSE = 2'd0,
		OP_OPEN = 2'd1,
		OP_STOP = 2'd2,
		OP_HALT = 2'd3
	} op_t;

	typedef struct packed {
		kind_t kind;
		op_t op;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLOSED = 3'd0,
		ST_OPENED = 3'd1,
		ST_CLOSING = 3'd2,
		ST_OPENING = 3'd3,
		ST_STOPPED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MV_CLOSE = 2'd0,
		MV_OPEN = 2'd1,
		MV_STOP = 2'd2,
		MV_IDLE = 2'd3
	} motion_t;

	typedef struct packed {
		status_t status;
		motion_t motion;
		logic [LIMIT_W-1:0] pos;
	} slot_t;

endpackage

[sv/curtain_travel_controller_top.sv]
// Curtain travel controller for CURTAINS slots. One command is taken per cycle
// (a transfer on cmd_valid/cmd_stall); it is classified on entry and goes into a
// four-entry queue, and the back end retires the queue head, updating every slot
// in parallel. A query or a matched single control passes the queue and the
// registered response stage before its response shows on rsp. cmd_stall rises
// only when the queue is full, which happens when responses are held by rsp_stall;
// ticks, all-controls, unknown commands and unmatched single controls give no
// response. Write the configuration registers only while nothing is in flight.
module curtain_travel_controller_top #(
	parameter int CURTAINS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [2:0] command,
	input logic [7:0] sub_id,
	input logic [7:0] operation,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [7:0] response_type,
	output logic [7:0] body_first,
	output logic [7:0] body_second,
	output logic [7:0] body_third,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int CMD_BITS = $bits(ctc_pkg::cmd_t);
	localparam int QW = CMD_BITS + CURTAINS;

	logic [ctc_pkg::LIMIT_W-1:0] limit_q;
	logic [ctc_pkg::ID_SLOTS-1:0][ctc_pkg::BYTE_W-1:0] ids_q;
	logic [ctc_pkg::BYTE_W-1:0] version_q;
	logic [ctc_pkg::BYTE_W-1:0] maker_q;
	logic [ctc_pkg::BYTE_W-1:0] feature_q;

	ctc_pkg::cmd_t front_cmd;
	logic [CURTAINS-1:0] front_mask;
	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic [QW-1:0] q_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ctc_pkg::LIMIT_RESET;
			ids_q <= '0;
			version_q <= ctc_pkg::VERSION_RESET;
			maker_q <= ctc_pkg::MAKER_RESET;
			feature_q <= ctc_pkg::FEATURE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ctc_pkg::REG_LIMIT: limit_q <= cfg_data;
				ctc_pkg::REG_ID0: ids_q[0] <= cfg_data[7:0];
				ctc_pkg::REG_ID1: ids_q[1] <= cfg_data[7:0];
				ctc_pkg::REG_ID2: ids_q[2] <= cfg_data[7:0];
				ctc_pkg::REG_ID3: ids_q[3] <= cfg_data[7:0];
				ctc_pkg::REG_VERSION: version_q <= cfg_data[7:0];
				ctc_pkg::REG_MAKER: maker_q <= cfg_data[7:0];
				ctc_pkg::REG_FEATURE: feature_q <= cfg_data[7:0];
				default: limit_q <= limit_q;
			endcase
		end
	end

	ctc_front #(
		.CURTAINS(CURTAINS)
	) u_front (
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.sub_id(sub_id),
		.operation(operation),
		.slot_ids(ids_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(front_cmd),
		.q_mask(front_mask)
	);

	ctc_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.data_in({front_cmd, front_mask}),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.data_out(q_out)
	);

	ctc_back #(
		.CURTAINS(CURTAINS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_cmd(ctc_pkg::cmd_t'(q_out[QW-1 -: CMD_BITS])),
		.q_mask(q_out[CURTAINS-1:0]),
		.q_pop(q_pop),
		.travel_limit(limit_q),
		.version_byte(version_q),
		.maker_code(maker_q),
		.feature_byte(feature_q),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.response_type(response_type),
		.body_first(body_first),
		.body_second(body_second),
		.body_third(body_third)
	);

endmodule

[sv/ctc_front.sv]
module ctc_front #(
	parameter int CURTAINS = 4
) (
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [ctc_pkg::CMD_W-1:0] command,
	input logic [ctc_pkg::BYTE_W-1:0] sub_id,
	input logic [ctc_pkg::BYTE_W-1:0] operation,
	input logic [ctc_pkg::ID_SLOTS-1:0][ctc_pkg::BYTE_W-1:0] slot_ids,
	input logic q_full,
	output logic q_push,
	output ctc_pkg::cmd_t q_cmd,
	output logic [CURTAINS-1:0] q_mask
);

	logic [CURTAINS-1:0] id_hit;
	logic keep;

	// slots without an id register answer to sub id zero
	for (genvar i = 0; i < CURTAINS; i++) begin : g_hit
		if (i < ctc_pkg::ID_SLOTS) begin : g_reg
			assign id_hit[i] = (sub_id == slot_ids[i]);
		end else begin : g_zero
			assign id_hit[i] = (sub_id == '0);
		end
	end

	always_comb begin
		q_mask = id_hit | {CURTAINS{sub_id[3:0] == ctc_pkg::ALL_NIBBLE}};
		keep = 1'b1;
		q_cmd.kind = ctc_pkg::K_TICK;
		unique case (command)
			ctc_pkg::CMD_TICK: q_cmd.kind = ctc_pkg::K_TICK;
			ctc_pkg::CMD_STATUS: q_cmd.kind = ctc_pkg::K_STATUS;
			ctc_pkg::CMD_CHAR: q_cmd.kind = ctc_pkg::K_CHAR;
			ctc_pkg::CMD_SINGLE: begin
				q_cmd.kind = ctc_pkg::K_SINGLE;
				// drop a single control that names no slot
				keep = |id_hit;
			end
			ctc_pkg::CMD_ALL: q_cmd.kind = ctc_pkg::K_ALL;
			default: keep = 1'b0;
		endcase
		unique case (operation)
			ctc_pkg::OPC_CLOSE: q_cmd.op = ctc_pkg::OP_CLOSE;
			ctc_pkg::OPC_OPEN: q_cmd.op = ctc_pkg::OP_OPEN;
			ctc_pkg::OPC_STOP: q_cmd.op = ctc_pkg::OP_STOP;
			default: q_cmd.op = ctc_pkg::OP_HALT;
		endcase
	end

	assign cmd_stall = q_full;
	assign q_push = cmd_valid && !q_full && keep;

endmodule

[sv/ctc_queue.sv]
module ctc_queue #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] data_in,
	output logic full,
	input logic pop,
	output logic valid,
	output logic [W-1:0] data_out
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	logic [W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == DEPTH_C);
	assign valid = (count_q != '0);
	assign data_out = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/ctc_back.sv]
module ctc_back #(
	parameter int CURTAINS = 4
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input ctc_pkg::cmd_t q_cmd,
	input logic [CURTAINS-1:0] q_mask,
	output logic q_pop,
	input logic [ctc_pkg::LIMIT_W-1:0] travel_limit,
	input logic [ctc_pkg::BYTE_W-1:0] version_byte,
	input logic [ctc_pkg::BYTE_W-1:0] maker_code,
	input logic [ctc_pkg::BYTE_W-1:0] feature_byte,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic [ctc_pkg::BYTE_W-1:0] response_type,
	output logic [ctc_pkg::BYTE_W-1:0] body_first,
	output logic [ctc_pkg::BYTE_W-1:0] body_second,
	output logic [ctc_pkg::BYTE_W-1:0] body_third
);

	localparam int LW = ctc_pkg::LIMIT_W;

	// travel by one step when one is set, otherwise only settle finished motion
	function automatic ctc_pkg::slot_t step(ctc_pkg::slot_t s, logic [LW-1:0] lim,
			logic one);
		ctc_pkg::slot_t r;
		logic [LW:0] up;
		r = s;
		up = {1'b0, s.pos} + {{LW{1'b0}}, one};
		unique case (s.motion)
			ctc_pkg::MV_CLOSE: begin
				if (s.pos == '0 || (one && s.pos == LW'(1))) begin
					r.pos = '0;
					r.motion = ctc_pkg::MV_IDLE;
					r.status = ctc_pkg::ST_CLOSED;
				end else begin
					r.pos = s.pos - {{(LW-1){1'b0}}, one};
				end
			end
			ctc_pkg::MV_OPEN: begin
				if (up > {1'b0, lim}) begin
					r.pos = lim;
					r.motion = ctc_pkg::MV_IDLE;
					r.status = ctc_pkg::ST_OPENED;
				end else begin
					r.pos = up[LW-1:0];
				end
			end
			ctc_pkg::MV_STOP: begin
				r.motion = ctc_pkg::MV_IDLE;
				r.status = ctc_pkg::ST_STOPPED;
			end
			default: r = s;
		endcase
		return r;
	endfunction

	// skip a slot that already is where the operation would take it
	function automatic ctc_pkg::slot_t operate(ctc_pkg::slot_t s, ctc_pkg::op_t op,
			logic hit);
		ctc_pkg::slot_t r;
		r = s;
		if (hit) begin
			unique case (op)
				ctc_pkg::OP_CLOSE: begin
					if (s.status != ctc_pkg::ST_CLOSING && s.status != ctc_pkg::ST_CLOSED) begin
						r.status = ctc_pkg::ST_CLOSING;
						r.motion = ctc_pkg::MV_CLOSE;
					end
				end
				ctc_pkg::OP_OPEN: begin
					if (s.status != ctc_pkg::ST_OPENING && s.status != ctc_pkg::ST_OPENED) begin
						r.status = ctc_pkg::ST_OPENING;
						r.motion = ctc_pkg::MV_OPEN;
					end
				end
				ctc_pkg::OP_STOP: begin
					if (s.status != ctc_pkg::ST_CLOSED && s.status != ctc_pkg::ST_OPENED) begin
						r.motion = ctc_pkg::MV_STOP;
					end
				end
				default: r.motion = ctc_pkg::MV_IDLE;
			endcase
		end
		return r;
	endfunction

	function automatic logic [ctc_pkg::BYTE_W-1:0] status_code(ctc_pkg::status_t st);
		logic [ctc_pkg::BYTE_W-1:0] c;
		unique case (st)
			ctc_pkg::ST_CLOSED: c = ctc_pkg::CODE_CLOSED;
			ctc_pkg::ST_OPENED: c = ctc_pkg::CODE_OPENED;
			ctc_pkg::ST_CLOSING: c = ctc_pkg::CODE_CLOSING;
			ctc_pkg::ST_OPENING: c = ctc_pkg::CODE_OPENING;
			default: c = ctc_pkg::CODE_STOPPED;
		endcase
		return c;
	endfunction

	ctc_pkg::slot_t slot_q [CURTAINS];
	ctc_pkg::slot_t settled [CURTAINS];
	ctc_pkg::slot_t acted [CURTAINS];
	ctc_pkg::slot_t slot_nxt [CURTAINS];

	logic is_tick;
	logic is_ctrl;
	logic has_result;
	logic [ctc_pkg::BYTE_W-1:0] type_nxt;
	logic [ctc_pkg::BYTE_W-1:0] first_nxt;
	logic [ctc_pkg::BYTE_W-1:0] second_nxt;
	logic [ctc_pkg::BYTE_W-1:0] third_nxt;

	logic rsp_valid_q;
	logic [ctc_pkg::BYTE_W-1:0] response_type_q;
	logic [ctc_pkg::BYTE_W-1:0] body_first_q;
	logic [ctc_pkg::BYTE_W-1:0] body_second_q;
	logic [ctc_pkg::BYTE_W-1:0] body_third_q;

	assign is_tick = (q_cmd.kind == ctc_pkg::K_TICK);
	assign is_ctrl = (q_cmd.kind == ctc_pkg::K_SINGLE) || (q_cmd.kind == ctc_pkg::K_ALL);

	always_comb begin
		for (int i = 0; i < CURTAINS; i++) begin
			settled[i] = step(slot_q[i], travel_limit, is_tick);
			acted[i] = step(operate(settled[i], q_cmd.op, q_mask[i]), travel_limit, 1'b0);
			slot_nxt[i] = is_ctrl ? acted[i] : settled[i];
		end
	end

	always_comb begin
		has_result = 1'b0;
		type_nxt = ctc_pkg::RSP_STATUS;
		first_nxt = '0;
		second_nxt = status_code(settled[0].status);
		third_nxt = '0;
		unique case (q_cmd.kind)
			ctc_pkg::K_STATUS: has_result = 1'b1;
			ctc_pkg::K_CHAR: begin
				has_result = 1'b1;
				type_nxt = ctc_pkg::RSP_CHAR;
				first_nxt = version_byte;
				second_nxt = maker_code;
				third_nxt = feature_byte;
			end
			ctc_pkg::K_SINGLE: begin
				has_result = 1'b1;
				type_nxt = ctc_pkg::RSP_CTRL;
				second_nxt = status_code(acted[0].status);
			end
			default: has_result = 1'b0;
		endcase
	end

	// hold the head while a result waits that cannot leave this cycle
	assign q_pop = q_valid && (!has_result || !rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CURTAINS; i++) begin
				slot_q[i].status <= ctc_pkg::ST_CLOSED;
				slot_q[i].motion <= ctc_pkg::MV_IDLE;
				slot_q[i].pos <= '0;
			end
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				for (int i = 0; i < CURTAINS; i++) begin
					slot_q[i] <= slot_nxt[i];
				end
			end
			if (q_pop && has_result) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && has_result) begin
			response_type_q <= type_nxt;
			body_first_q <= first_nxt;
			body_second_q <= second_nxt;
			body_third_q <= third_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign response_type = response_type_q;
	assign body_first = body_first_q;
	assign body_second = body_second_q;
	assign body_third = body_third_q;

endmodule
